// ===== rtl/core/qfct_pkg.sv =====
// ----------------------------------------------------------------------------
// qfct_pkg: flow credit tracker shared types
// Event kinds, register indexes and the result record used across the block.
// ----------------------------------------------------------------------------
package qfct_pkg;

	localparam int unsigned CW = 62;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
	localparam logic [CW-1:0] CONN_WINDOW_RST = 62'd1048576;
	localparam logic [CW-1:0] STREAM_WINDOW_RST = 62'd262144;

	typedef enum logic [3:0] {
		K_CONN_LIMIT   = 4'd0,
		K_STREAM_LIMIT = 4'd1,
		K_CREATE       = 4'd2,
		K_SENT         = 4'd3,
		K_RECV         = 4'd4,
		K_CONN_UPD     = 4'd5,
		K_STREAM_UPD   = 4'd6,
		K_REMOVE       = 4'd7,
		K_QUERY        = 4'd8
	} kind_t;

	localparam logic REG_CONN_WINDOW = 1'b0;
	localparam logic REG_STREAM_WINDOW = 1'b1;

	typedef struct packed {
		logic [3:0]    kind;
		logic [CW-1:0] flow_id;
		logic [CW-1:0] amount;
		logic          frame_room;
	} event_t;

	typedef struct packed {
		logic          stream_found;
		logic          conn_blocked;
		logic [CW-1:0] conn_send_window;
		logic          stream_blocked;
		logic [CW-1:0] stream_send_window;
		logic          conn_update_due;
		logic          stream_update_due;
		logic [CW-1:0] grant_limit;
		logic          update_issued;
		logic          table_full;
	} result_t;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? CNT_MAX : s[CW-1:0];
	endfunction

	function automatic logic half_reached(input logic [CW-1:0] c, input logic [CW-1:0] l);
		return {c, 1'b0} >= {1'b0, l};
	endfunction

endpackage

// ===== rtl/core/qfct_if.sv =====
// ----------------------------------------------------------------------------
// qfct_if: valid/ready channel interfaces
// Event, result and configuration write channels.
// ----------------------------------------------------------------------------
interface qfct_evt_if import qfct_pkg::*; ();
	logic   valid;
	logic   ready;
	event_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qfct_res_if import qfct_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qfct_cfg_if import qfct_pkg::*; ();
	logic          valid;
	logic          ready;
	logic          index;
	logic [CW-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/qfct_front.sv =====
// ----------------------------------------------------------------------------
// qfct_front: event intake
// Registers incoming events into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module qfct_front import qfct_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  event_t in_data,
	output logic   q_valid,
	input  logic   q_pop,
	output event_t q_data
);
	event_t     buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_data   = buf_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop && cnt_q == 2'd1) |=> cnt_q == 2'd2)
		else $error("queue count lost a push");
endmodule

// ===== rtl/core/qfct_back.sv =====
// ----------------------------------------------------------------------------
// qfct_back: credit execution
// Stage 1 matches the stream id against the table; stage 2 updates the
// entry and connection counters and registers the result.
// ----------------------------------------------------------------------------
module qfct_back import qfct_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  event_t        q_data,
	input  logic [CW-1:0] conn_window,
	input  logic [CW-1:0] stream_window,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res_data
);
	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0] id_q [TABLE_ENTRIES];
	logic [CW-1:0] sb_q [TABLE_ENTRIES];
	logic [CW-1:0] sl_q [TABLE_ENTRIES];
	logic [CW-1:0] rb_q [TABLE_ENTRIES];
	logic [CW-1:0] rl_q [TABLE_ENTRIES];

	logic [CW-1:0] c_sb_q, c_sl_q, c_rb_q, c_rl_q;

	// stage 1 registers
	logic          v_s1;
	event_t        ev_s1;
	logic          hit_s1, free_s1;
	logic [IW-1:0] hidx_s1, fidx_s1;
	logic [CW-1:0] sb_s1, sl_s1, rb_s1, rl_s1;

	logic          res_v_q;
	result_t       res_q;

	// match and free-slot search
	logic          hit, fre;
	logic [IW-1:0] hidx, fidx;
	always_comb begin
		hit = 1'b0; fre = 1'b0; hidx = '0; fidx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && id_q[i] == q_data.flow_id) begin
				hit = 1'b1; hidx = IW'(i);
			end
			if (!valid_q[i]) begin
				fre = 1'b1; fidx = IW'(i);
			end
		end
	end

	logic s2_free;
	assign s2_free = !res_v_q || res_ready;
	// stage 1 waits while stage 2 is busy so the match sees fresh state
	assign q_pop = q_valid && !v_s1 && s2_free;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ev_s1 <= q_data; hit_s1 <= hit; free_s1 <= fre;
			hidx_s1 <= hidx; fidx_s1 <= fidx;
			sb_s1 <= sb_q[hidx]; sl_s1 <= sl_q[hidx];
			rb_s1 <= rb_q[hidx]; rl_s1 <= rl_q[hidx];
		end
	end

	// stage 2 compute
	logic          found, full, issued, mk, we;
	logic [IW-1:0] e;
	logic [CW-1:0] sb, sl, rb, rl, lim, a, b, csb, csl, crb, crl;
	always_comb begin
		found = hit_s1; full = 1'b0; issued = 1'b0; mk = 1'b0; we = 1'b0;
		e = hidx_s1; sb = sb_s1; sl = sl_s1; rb = rb_s1; rl = rl_s1; lim = '0;
		csb = c_sb_q; csl = c_sl_q; crb = c_rb_q; crl = c_rl_q; a = '0; b = '0;
		case (kind_t'(ev_s1.kind))
			K_CONN_LIMIT: if (ev_s1.amount > csl) csl = ev_s1.amount;
			K_STREAM_LIMIT, K_CREATE: begin
				if (!hit_s1) begin
					mk = free_s1; full = !free_s1;
				end else if (ev_s1.kind == K_STREAM_LIMIT && ev_s1.amount > sl) begin
					sl = ev_s1.amount; we = 1'b1;
				end
			end
			K_SENT: begin
				if (hit_s1) begin sb = sat_add(sb, ev_s1.amount); we = 1'b1; end
				csb = sat_add(csb, ev_s1.amount);
			end
			K_RECV: begin
				if (!hit_s1) begin
					mk = free_s1; full = !free_s1;
					if (free_s1) begin
						sb = '0; sl = '0; rl = stream_window;
						rb = ev_s1.amount;
					end
				end else begin
					rb = sat_add(rb, ev_s1.amount); we = 1'b1;
				end
				crb = sat_add(crb, ev_s1.amount);
			end
			K_CONN_UPD: if (ev_s1.frame_room) begin
				a = sat_add(crl, conn_window); b = sat_add(crb, conn_window);
				lim = (a > b) ? a : b; crl = lim; issued = 1'b1;
			end
			K_STREAM_UPD: if (ev_s1.frame_room && hit_s1) begin
				a = sat_add(rl, stream_window); b = sat_add(rb, stream_window);
				lim = (a > b) ? a : b; rl = lim; issued = 1'b1; we = 1'b1;
			end
			K_REMOVE: found = 1'b0;
			default: ;
		endcase
		if (mk) begin
			found = 1'b1; e = fidx_s1;
			if (ev_s1.kind != K_RECV) begin
				sb = '0; sl = ev_s1.amount; rb = '0; rl = stream_window;
			end
		end
	end

	// table and connection state
	always_ff @(posedge clk) begin
		if (v_s1 && (we || mk)) begin
			sb_q[e] <= sb; sl_q[e] <= sl; rb_q[e] <= rb; rl_q[e] <= rl;
		end
		if (v_s1 && mk) id_q[e] <= ev_s1.flow_id;
		if (v_s1) begin
			res_q.stream_found       <= found;
			res_q.conn_blocked       <= csb >= csl;
			res_q.conn_send_window   <= (csl > csb) ? csl - csb : '0;
			res_q.stream_blocked     <= found ? (sb >= sl) : 1'b1;
			res_q.stream_send_window <= (found && sl > sb) ? sl - sb : '0;
			res_q.conn_update_due    <= half_reached(crb, crl);
			res_q.stream_update_due  <= found && half_reached(rb, rl);
			res_q.grant_limit        <= lim;
			res_q.update_issued      <= issued;
			res_q.table_full         <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; v_s1 <= 1'b0; res_v_q <= 1'b0;
			c_sb_q <= '0; c_sl_q <= '0; c_rb_q <= '0; c_rl_q <= CONN_WINDOW_RST;
		end else begin
			v_s1 <= q_pop;
			if (v_s1) res_v_q <= 1'b1;
			else if (res_ready) res_v_q <= 1'b0;
			if (v_s1) begin
				c_sb_q <= csb; c_sl_q <= csl; c_rb_q <= crb; c_rl_q <= crl;
				if (mk) valid_q[e] <= 1'b1;
				if (ev_s1.kind == K_REMOVE && hit_s1) valid_q[hidx_s1] <= 1'b0;
			end
		end
	end

	assign res_valid = res_v_q;
	assign res_data  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) v_s1 |-> s2_free)
		else $error("stage 2 overwritten while result pending");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |=> !q_pop)
		else $error("back end took two events back to back");
	assert property (@(posedge clk) disable iff (!arst_n) (v_s1 && mk) |-> !hit_s1)
		else $error("entry created for a known stream");
endmodule

// ===== rtl/core/quic_flow_credit_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// quic_flow_credit_tracker_unit: QUIC flow credit tracker
// Connection and per-stream send/receive credit with a stream table.
// ----------------------------------------------------------------------------
// Path: the queue, then the stage 1 match registers, then the update and registered result.
// The back end takes no new event while one is in stage 1 or a result waits on res.ready.
// Reset: asynchronous; clears counters and entry valid bits, windows to defaults.
// A two-entry queue decouples event intake from the table engine.
module quic_flow_credit_tracker_unit import qfct_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input logic clk,
	input logic arst_n,
	qfct_evt_if.sink   evt,
	qfct_res_if.source res,
	qfct_cfg_if.sink   cfg
);
	logic [CW-1:0] conn_window_q, stream_window_q;
	logic          q_valid, q_pop;
	event_t        q_data;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_window_q   <= CONN_WINDOW_RST;
			stream_window_q <= STREAM_WINDOW_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CONN_WINDOW:   conn_window_q <= cfg.wdata;
				REG_STREAM_WINDOW: stream_window_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	qfct_front u_front (
		.clk, .arst_n,
		.in_valid(evt.valid), .in_ready(evt.ready), .in_data(evt.data),
		.q_valid, .q_pop, .q_data
	);

	qfct_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk, .arst_n,
		.q_valid, .q_pop, .q_data,
		.conn_window(conn_window_q), .stream_window(stream_window_q),
		.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
	);
endmodule
